// ===== rtl/rci_pkg.sv =====
`default_nettype none
package rci_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int R_W       = COORD_W - 1;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int A_W       = 2 * COORD_W;
  localparam int BH_W      = 2 * COORD_W + 2;
  localparam int R2_W      = 2 * R_W;
  localparam int DIST_W    = 2 * DIFF_W + 1;
  localparam int MUL_W     = BH_W;
  localparam int MUL_LIMBS = 3;
  localparam int MUL_LW    = (MUL_W + MUL_LIMBS - 1) / MUL_LIMBS;
  localparam int MUL_PADW  = MUL_LW * MUL_LIMBS;
  localparam int MUL_LAT   = 3;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int Q_W       = PROD_W + 1;
  localparam int SQ_W      = 4 * COORD_W - 2;
  localparam int RT_W      = SQ_W / 2;
  localparam int SQ_RW     = RT_W + 2;
  localparam int NM_W      = BH_W + FRAC_W;
  localparam int DV_W      = A_W + COORD_W;
  localparam int DIV_LAT   = COORD_W + 1;
  localparam int SUM_W     = 2 * COORD_W - FRAC_W + 1;
  localparam int NSTG      = 4 + MUL_LAT + 1 + RT_W + 1 + DIV_LAT + 2;

  localparam logic [COORD_W-1:0] T_NEG_ONE = {{(COORD_W-FRAC_W){1'b1}}, {FRAC_W{1'b0}}};
  localparam logic [COORD_W-1:0] SAT_MAX   = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_MIN   = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [1:0] FIFO_EMPTY = 2'd0;
  localparam logic [1:0] FIFO_FULL  = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t                 ox;
    coord_t                 oy;
    coord_t                 dx;
    coord_t                 dy;
    logic [A_W-1:0]         a;
    logic signed [BH_W-1:0] bh;
    logic                   in_circ;
    logic                   ok;
    logic                   neg;
  } side_t;

  typedef struct packed {
    logic   hit;
    logic   inside_res;
    coord_t hit_time;
    coord_t hit_x;
    coord_t hit_y;
  } out_t;

  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'($signed(SAT_MAX));
    lo = SUM_W'($signed(SAT_MIN));
    if (v > hi) begin
      return SAT_MAX;
    end else if (v < lo) begin
      return SAT_MIN;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rci_if.sv =====
`default_nettype none
interface rci_in_if import rci_pkg::*; ();
  logic               valid;
  logic               ready;
  coord_t             origin_x;
  coord_t             origin_y;
  coord_t             dir_x;
  coord_t             dir_y;
  coord_t             center_x;
  coord_t             center_y;
  logic [R_W-1:0]     radius;

  modport source (output valid, origin_x, origin_y, dir_x, dir_y, center_x, center_y,
                  radius, input ready);
  modport sink   (input valid, origin_x, origin_y, dir_x, dir_y, center_x, center_y,
                  radius, output ready);
endinterface

interface rci_out_if import rci_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   hit;
  logic   inside_res;
  coord_t hit_time;
  coord_t hit_x;
  coord_t hit_y;

  modport source (output valid, hit, inside_res, hit_time, hit_x, hit_y, input ready);
  modport sink   (input valid, hit, inside_res, hit_time, hit_x, hit_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/rci_wmul.sv =====
`default_nettype none
module rci_wmul import rci_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [MUL_W-1:0]  a,
  input  wire logic [MUL_W-1:0]  b,
  output logic      [PROD_W-1:0] p
);

  logic [MUL_PADW-1:0]   a_pad;
  logic [MUL_PADW-1:0]   b_pad;
  logic [2*MUL_LW-1:0]   pp_r   [MUL_LIMBS][MUL_LIMBS];
  logic [2*MUL_PADW-1:0] row_nxt [MUL_LIMBS];
  logic [2*MUL_PADW-1:0] row_r   [MUL_LIMBS];
  logic [2*MUL_PADW-1:0] sum_nxt;
  logic [2*MUL_PADW-1:0] p_r;

  assign a_pad = MUL_PADW'(a);
  assign b_pad = MUL_PADW'(b);

  // limb products, then row sums, then the total
  always_comb begin
    for (int i = 0; i < MUL_LIMBS; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < MUL_LIMBS; j++) begin
        row_nxt[i] = row_nxt[i] + ((2*MUL_PADW)'(pp_r[i][j]) << (MUL_LW * j));
      end
    end
    sum_nxt = '0;
    for (int i = 0; i < MUL_LIMBS; i++) begin
      sum_nxt = sum_nxt + (row_r[i] << (MUL_LW * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < MUL_LIMBS; i++) begin
        for (int j = 0; j < MUL_LIMBS; j++) begin
          pp_r[i][j] <= a_pad[i*MUL_LW +: MUL_LW] * b_pad[j*MUL_LW +: MUL_LW];
        end
        row_r[i] <= row_nxt[i];
      end
      p_r <= sum_nxt;
    end
  end

  assign p = p_r[PROD_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/rci_sqrt.sv =====
`default_nettype none
module rci_sqrt import rci_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [SQ_W-1:0]  x,
  output logic      [RT_W-1:0]  root
);

  logic [SQ_RW-1:0] rem_r    [RT_W];
  logic [RT_W-1:0]  root_r   [RT_W];
  logic [SQ_W-1:0]  x_r      [RT_W];
  logic [SQ_RW-1:0] rem_p    [RT_W];
  logic [RT_W-1:0]  root_p   [RT_W];
  logic [SQ_W-1:0]  x_p      [RT_W];
  logic [SQ_RW-1:0] rem_sh   [RT_W];
  logic [SQ_RW-1:0] trial    [RT_W];
  logic [SQ_RW-1:0] rem_nxt  [RT_W];
  logic [RT_W-1:0]  root_nxt [RT_W];
  logic [SQ_W-1:0]  x_nxt    [RT_W];

  // one root bit per stage, MSB first
  always_comb begin
    for (int k = 0; k < RT_W; k++) begin
      if (k == 0) begin
        rem_p[k]  = '0;
        root_p[k] = '0;
        x_p[k]    = x;
      end else begin
        rem_p[k]  = rem_r[k-1];
        root_p[k] = root_r[k-1];
        x_p[k]    = x_r[k-1];
      end
      rem_sh[k] = {rem_p[k][SQ_RW-3:0], x_p[k][SQ_W-1 -: 2]};
      trial[k]  = {root_p[k], 2'b01};
      if (rem_sh[k] >= trial[k]) begin
        rem_nxt[k]  = rem_sh[k] - trial[k];
        root_nxt[k] = {root_p[k][RT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_sh[k];
        root_nxt[k] = {root_p[k][RT_W-2:0], 1'b0};
      end
      x_nxt[k] = x_p[k] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RT_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        x_r[k]    <= x_nxt[k];
      end
    end
  end

  assign root = root_r[RT_W-1];

endmodule
`default_nettype wire

// ===== rtl/rci_div.sv =====
`default_nettype none
module rci_div import rci_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [NM_W-1:0]    n,
  input  wire logic [A_W-1:0]     d,
  output logic      [COORD_W-1:0] q,
  output logic                    rem_nz,
  output logic                    ovf
);

  logic [DV_W-1:0]    r0_r;
  logic [A_W-1:0]     d0_r;
  logic               ovf0_r;
  logic [DV_W-1:0]    r_r   [COORD_W];
  logic [COORD_W-1:0] q_r   [COORD_W];
  logic [A_W-1:0]     d_r   [COORD_W];
  logic               ovf_r [COORD_W];
  logic [DV_W-1:0]    r_p   [COORD_W];
  logic [COORD_W-1:0] q_p   [COORD_W];
  logic [A_W-1:0]     d_p   [COORD_W];
  logic               ovf_p [COORD_W];
  logic [DV_W-1:0]    trial [COORD_W];
  logic [DV_W-1:0]    r_nxt [COORD_W];
  logic [COORD_W-1:0] q_nxt [COORD_W];
  logic               ovf_nxt;

  // quotient must fit COORD_W bits, else saturate downstream
  assign ovf_nxt = DV_W'(n) >= {d, {COORD_W{1'b0}}};

  always_comb begin
    for (int k = 0; k < COORD_W; k++) begin
      if (k == 0) begin
        r_p[k]   = r0_r;
        q_p[k]   = '0;
        d_p[k]   = d0_r;
        ovf_p[k] = ovf0_r;
      end else begin
        r_p[k]   = r_r[k-1];
        q_p[k]   = q_r[k-1];
        d_p[k]   = d_r[k-1];
        ovf_p[k] = ovf_r[k-1];
      end
      trial[k] = DV_W'(d_p[k]) << (COORD_W - 1 - k);
      if (r_p[k] >= trial[k]) begin
        r_nxt[k] = r_p[k] - trial[k];
        q_nxt[k] = {q_p[k][COORD_W-2:0], 1'b1};
      end else begin
        r_nxt[k] = r_p[k];
        q_nxt[k] = {q_p[k][COORD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r   <= DV_W'(n);
      d0_r   <= d;
      ovf0_r <= ovf_nxt;
      for (int k = 0; k < COORD_W; k++) begin
        r_r[k]   <= r_nxt[k];
        q_r[k]   <= q_nxt[k];
        d_r[k]   <= d_p[k];
        ovf_r[k] <= ovf_p[k];
      end
    end
  end

  assign q      = q_r[COORD_W-1];
  assign rem_nz = |r_r[COORD_W-1];
  assign ovf    = ovf_r[COORD_W-1];

endmodule
`default_nettype wire

// ===== rtl/ray_circle_intersect_core.sv =====
// Throughput: one transaction per cycle; a 2-entry result buffer decouples the
// sides, and the whole pipeline holds only when that buffer is full.
// Depth is set by the bit-per-stage square root (63) and divider (33) chains.
// Reset: synchronous, active low; clears stage valid bits and empties the result buffer.
`default_nettype none
module ray_circle_intersect_core import rci_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rci_in_if.sink     in_chan,
  rci_out_if.source  out_chan
);

  logic            en;
  logic [NSTG-1:0] vld_r;

  // s1
  coord_t                    s1_ox_r, s1_oy_r, s1_dx_r, s1_dy_r;
  logic signed [DIFF_W-1:0]  s1_ddx_r, s1_ddy_r;
  logic [R_W-1:0]            s1_rad_r;
  // s2
  coord_t                    s2_ox_r, s2_oy_r, s2_dx_r, s2_dy_r;
  logic                      s2_dz_r;
  logic signed [A_W-1:0]     s2_dxdx_r, s2_dydy_r;
  logic signed [DIFF_W+COORD_W-1:0] s2_ddxdx_r, s2_ddydy_r, s2_ddxdy_r, s2_ddydx_r;
  logic signed [2*DIFF_W-1:0] s2_ddxddx_r, s2_ddyddy_r;
  logic [R2_W-1:0]           s2_rr_r;
  // s3
  side_t                     s3_side_nxt, s3_side_r;
  logic signed [BH_W-1:0]    s3_cross_nxt, s3_cross_r;
  logic signed [DIST_W-1:0]  s3_dist;
  logic [R2_W-1:0]           s3_rr_r;
  // s4
  side_t                     s4_side_r;
  logic [MUL_W-1:0]          s4_cmag_r, s4_a_r, s4_rr_r;
  // multiplier outputs
  logic [PROD_W-1:0]         cc_p, ar_p;
  side_t                     side_m_r [MUL_LAT];
  // s8
  logic signed [Q_W-1:0]     s8_q;
  side_t                     s8_side_nxt, s8_side_r;
  logic [SQ_W-1:0]           s8_x_r;
  // sqrt
  logic [RT_W-1:0]           root;
  side_t                     side_q_r [RT_W];
  // s9
  logic signed [BH_W:0]      s9_diff;
  logic [BH_W:0]             s9_abs;
  logic [BH_W-1:0]           s9_mag;
  side_t                     s9_side_nxt, s9_side_r;
  logic [NM_W-1:0]           s9_n_r;
  // divider
  logic [COORD_W-1:0]        dv_q;
  logic                      dv_rem_nz, dv_ovf;
  side_t                     side_d_r [DIV_LAT];
  // s10
  logic [COORD_W:0]          s10_m;
  coord_t                    s10_t_nxt, s10_t_r;
  side_t                     s10_side_r;
  // s11
  logic signed [A_W-1:0]     s11_px_r, s11_py_r;
  side_t                     s11_side_r;
  coord_t                    s11_t_r;
  coord_t                    hx, hy;
  out_t                      res;
  // result buffer
  out_t                      buf_r [FIFO_FULL];
  logic                      wr_ptr_r, rd_ptr_r;
  logic [1:0]                cnt_r, cnt_nxt;
  logic                      push, pop;
  out_t                      head;

  assign en            = (cnt_r != FIFO_FULL);
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_chan.valid};
    end
  end

  // s3 combine
  always_comb begin
    s3_side_nxt.ox      = s2_ox_r;
    s3_side_nxt.oy      = s2_oy_r;
    s3_side_nxt.dx      = s2_dx_r;
    s3_side_nxt.dy      = s2_dy_r;
    s3_side_nxt.a       = $unsigned(s2_dxdx_r) + $unsigned(s2_dydy_r);
    s3_side_nxt.bh      = BH_W'(s2_ddxdx_r) + BH_W'(s2_ddydy_r);
    s3_dist             = DIST_W'(s2_ddxddx_r) + DIST_W'(s2_ddyddy_r);
    s3_side_nxt.in_circ = s3_dist <= $signed({{(DIST_W-R2_W){1'b0}}, s2_rr_r});
    s3_side_nxt.ok      = !s2_dz_r;
    s3_side_nxt.neg     = 1'b0;
    s3_cross_nxt        = BH_W'(s2_ddxdy_r) - BH_W'(s2_ddydx_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ox_r   <= in_chan.origin_x;
      s1_oy_r   <= in_chan.origin_y;
      s1_dx_r   <= in_chan.dir_x;
      s1_dy_r   <= in_chan.dir_y;
      s1_ddx_r  <= DIFF_W'(in_chan.center_x) - DIFF_W'(in_chan.origin_x);
      s1_ddy_r  <= DIFF_W'(in_chan.center_y) - DIFF_W'(in_chan.origin_y);
      s1_rad_r  <= in_chan.radius;

      s2_ox_r     <= s1_ox_r;
      s2_oy_r     <= s1_oy_r;
      s2_dx_r     <= s1_dx_r;
      s2_dy_r     <= s1_dy_r;
      s2_dz_r     <= (s1_dx_r == '0) && (s1_dy_r == '0);
      s2_dxdx_r   <= s1_dx_r * s1_dx_r;
      s2_dydy_r   <= s1_dy_r * s1_dy_r;
      s2_ddxdx_r  <= s1_ddx_r * s1_dx_r;
      s2_ddydy_r  <= s1_ddy_r * s1_dy_r;
      s2_ddxdy_r  <= s1_ddx_r * s1_dy_r;
      s2_ddydx_r  <= s1_ddy_r * s1_dx_r;
      s2_ddxddx_r <= s1_ddx_r * s1_ddx_r;
      s2_ddyddy_r <= s1_ddy_r * s1_ddy_r;
      s2_rr_r     <= s1_rad_r * s1_rad_r;

      s3_side_r  <= s3_side_nxt;
      s3_cross_r <= s3_cross_nxt;
      s3_rr_r    <= s2_rr_r;

      s4_side_r <= s3_side_r;
      s4_cmag_r <= $unsigned(s3_cross_r[BH_W-1] ? -s3_cross_r : s3_cross_r);
      s4_a_r    <= MUL_W'(s3_side_r.a);
      s4_rr_r   <= MUL_W'(s3_rr_r);
    end
  end

  // discriminant / 4 = A*r^2 - cross^2
  rci_wmul u_mul_cc (.clk(clk), .en(en), .a(s4_cmag_r), .b(s4_cmag_r), .p(cc_p));
  rci_wmul u_mul_ar (.clk(clk), .en(en), .a(s4_a_r),    .b(s4_rr_r),   .p(ar_p));

  assign s8_q = $signed({1'b0, ar_p}) - $signed({1'b0, cc_p});

  always_comb begin
    s8_side_nxt    = side_m_r[MUL_LAT-1];
    s8_side_nxt.ok = side_m_r[MUL_LAT-1].ok && !s8_q[Q_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_m_r[0] <= s4_side_r;
      for (int k = 1; k < MUL_LAT; k++) begin
        side_m_r[k] <= side_m_r[k-1];
      end
      s8_side_r <= s8_side_nxt;
      s8_x_r    <= s8_q[Q_W-1] ? '0 : s8_q[SQ_W-1:0];
    end
  end

  rci_sqrt u_sqrt (.clk(clk), .en(en), .x(s8_x_r), .root(root));

  always_comb begin
    s9_diff         = (BH_W+1)'(side_q_r[RT_W-1].bh) - $signed({2'b00, root});
    s9_abs          = $unsigned(s9_diff[BH_W] ? -s9_diff : s9_diff);
    s9_mag          = s9_abs[BH_W-1:0];
    s9_side_nxt     = side_q_r[RT_W-1];
    s9_side_nxt.neg = s9_diff[BH_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q_r[0] <= s8_side_r;
      for (int k = 1; k < RT_W; k++) begin
        side_q_r[k] <= side_q_r[k-1];
      end
      s9_side_r <= s9_side_nxt;
      s9_n_r    <= {s9_mag, {FRAC_W{1'b0}}};
    end
  end

  rci_div u_div (
    .clk(clk), .en(en), .n(s9_n_r), .d(s9_side_r.a),
    .q(dv_q), .rem_nz(dv_rem_nz), .ovf(dv_ovf)
  );

  // floor of the signed quotient, saturated; T_NEG_ONE on a miss
  always_comb begin
    s10_m = {1'b0, dv_q} + (COORD_W+1)'(dv_rem_nz);
    priority if (!side_d_r[DIV_LAT-1].ok) begin
      s10_t_nxt = T_NEG_ONE;
    end else if (dv_ovf) begin
      s10_t_nxt = side_d_r[DIV_LAT-1].neg ? SAT_MIN : SAT_MAX;
    end else if (!side_d_r[DIV_LAT-1].neg) begin
      s10_t_nxt = dv_q[COORD_W-1] ? SAT_MAX : dv_q;
    end else if (s10_m > {1'b0, SAT_MIN}) begin
      s10_t_nxt = SAT_MIN;
    end else begin
      s10_t_nxt = -s10_m[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r[0] <= s9_side_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_d_r[k] <= side_d_r[k-1];
      end
      s10_side_r <= side_d_r[DIV_LAT-1];
      s10_t_r    <= s10_t_nxt;

      s11_side_r <= s10_side_r;
      s11_t_r    <= s10_t_r;
      s11_px_r   <= s10_side_r.dx * s10_t_r;
      s11_py_r   <= s10_side_r.dy * s10_t_r;
    end
  end

  always_comb begin
    hx = sat_coord(SUM_W'($signed(s11_px_r[A_W-1:FRAC_W])) + SUM_W'(s11_side_r.ox));
    hy = sat_coord(SUM_W'($signed(s11_py_r[A_W-1:FRAC_W])) + SUM_W'(s11_side_r.oy));
    res.hit        = s11_side_r.ok;
    res.inside_res = s11_side_r.in_circ;
    res.hit_time   = s11_t_r;
    res.hit_x      = s11_side_r.ok ? hx : '0;
    res.hit_y      = s11_side_r.ok ? hy : '0;
  end

  // result buffer
  assign push = en && vld_r[NSTG-1];
  assign pop  = out_chan.valid && out_chan.ready;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= FIFO_EMPTY;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  assign head                = buf_r[rd_ptr_r];
  assign out_chan.valid      = (cnt_r != FIFO_EMPTY);
  assign out_chan.hit        = head.hit;
  assign out_chan.inside_res = head.inside_res;
  assign out_chan.hit_time   = head.hit_time;
  assign out_chan.hit_x      = head.hit_x;
  assign out_chan.hit_y      = head.hit_y;

`ifndef SYNTHESIS
  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.hit |->
      out_chan.hit_time == T_NEG_ONE && out_chan.hit_x == '0 && out_chan.hit_y == '0)
    else $error("miss transaction with nonzero point or time");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == FIFO_FULL))
    else $error("result buffer overflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == FIFO_EMPTY || cnt_r == 2'd1 || cnt_r == FIFO_FULL)
    else $error("result buffer count out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire
